[design/bvs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared widths, command and status codes for the bounded vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int WORD_W       = 32;
  localparam int CNT_W        = 8;
  localparam int POS_W        = 7;
  localparam int CMD_W        = 3;
  localparam int ST_W         = 2;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 48;
  localparam int DEPTH_DEFAULT = 128;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_READ_FIRST = 3'd2,
    CMD_READ_LAST = 3'd3,
    CMD_READ_AT   = 3'd4,
    CMD_WRITE_AT  = 3'd5,
    CMD_ERASE_AT  = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage
`default_nettype wire

[design/bvs_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_mem
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bvs_mem
  import bvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/bvs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_ctrl
// Command sequencer: decodes a beat, drives the store, shifts on erase and
// holds the result register.
// ----------------------------------------------------------------------------
module bvs_ctrl
  import bvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic [CNT_W-1:0]       cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        mem_we,
  output logic      [AW-1:0]          mem_waddr,
  output logic      [WORD_W-1:0]      mem_wdata,
  output logic                        mem_re,
  output logic      [AW-1:0]          mem_raddr,
  input  wire logic [WORD_W-1:0]      mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ERASE,
    S_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       limit_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   use_rd_r, use_rd_nxt;
  status_t                st_r, st_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  cmd_t              cmd;
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] wval;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  count_dec;
  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              bad_pos;
  logic              slot_free;

  assign cmd       = cmd_t'(in_tdata[CMD_W-1:0]);
  assign pos       = in_tdata[CMD_W +: POS_W];
  assign wval      = in_tdata[CMD_W+POS_W +: WORD_W];
  assign pos_ext   = CNT_W'(pos);
  assign pos_inc   = pos_ext + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r >= limit_r) || (32'(count_r) >= 32'(DEPTH));
  assign bad_pos   = (pos_ext >= count_r);
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    use_rd_nxt = use_rd_r;
    st_nxt     = st_r;
    mem_we     = 1'b0;
    mem_waddr  = AW'(count_r);
    mem_wdata  = wval;
    mem_re     = 1'b0;
    mem_raddr  = AW'(count_dec);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_RESP;
          use_rd_nxt = 1'b0;
          st_nxt     = ST_OK;
          case (cmd)
            CMD_PUSH: begin
              if (is_full) begin
                st_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                use_rd_nxt = 1'b1;
                count_nxt  = count_dec;
              end
            end
            CMD_READ_FIRST: begin
              mem_raddr = '0;
              if (is_empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                use_rd_nxt = 1'b1;
              end
            end
            CMD_READ_LAST: begin
              if (is_empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                use_rd_nxt = 1'b1;
              end
            end
            CMD_READ_AT: begin
              mem_raddr = AW'(pos_ext);
              if (bad_pos) begin
                st_nxt = ST_BADPOS;
              end else begin
                mem_re     = 1'b1;
                use_rd_nxt = 1'b1;
              end
            end
            CMD_WRITE_AT: begin
              mem_waddr = AW'(pos_ext);
              if (bad_pos) begin
                st_nxt = ST_BADPOS;
              end else begin
                mem_we = 1'b1;
              end
            end
            CMD_ERASE_AT: begin
              mem_raddr = AW'(pos_inc);
              if (bad_pos) begin
                st_nxt = ST_BADPOS;
              end else begin
                count_nxt = count_dec;
                idx_nxt   = pos_ext;
                // shift needed unless the last word is erased
                if (pos_inc < count_r) begin
                  mem_re    = 1'b1;
                  state_nxt = S_ERASE;
                end
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_ERASE: begin
        // count_r already holds the count after erase
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = mem_rdata;
        mem_raddr = AW'(idx_r + CNT_W'(2));
        if ((idx_r + CNT_W'(1)) < count_r) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      use_rd_r    <= 1'b0;
      st_r        <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      use_rd_r <= use_rd_nxt;
      st_r     <= st_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RESP && slot_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == S_RESP && slot_free) begin
      out_data_r <= OUT_TDATA_W'({st_r, count_r,
                                  (use_rd_r ? mem_rdata : {WORD_W{1'b0}})});
    end
  end

endmodule
`default_nettype wire

[design/bounded_vector_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_vector_store
// Bounded array of signed 32-bit words with a fill count and a push limit.
// ----------------------------------------------------------------------------
// usage:
//   in_*   : command beats. tdata = cmd[2:0], position[9:3], write_value[41:10]
//   out_*  : one result beat per command. tdata = read_value[31:0],
//            element_count[39:32], status[41:40]
//   cfg_*  : count_limit write, always ready; write only while the block is idle
// commands: push, pop, read first, read last, read at, overwrite at,
//   erase at (later words move down one place), clear
// order: an accepted command goes to the result state, which loads the result
//   register; erase at a position p first moves each of the count - p - 1 later
//   words down one place in the erase state. A command is taken only while the
//   sequencer is idle, so the next one waits until the previous result is loaded;
//   the registered read data of the word store is ready in the result state
// stall: a finished result waits in the output register; the next command is
//   still taken and processed, and it holds in its last cycle until the
//   output register frees up
// reset: count goes to zero, count_limit to 100, no result pending; the word
//   store needs no clearing since only words below the count are ever read
// ----------------------------------------------------------------------------
module bounded_vector_store
  import bvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // count_limit write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data,
  // command beats: cmd, position, write_value (lowest first), zero padded
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result beats: read_value, element_count, status (lowest first), zero padded
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(DEPTH);

  // store access from the sequencer
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // the limit register takes a write on any cycle
  assign cfg_ready = 1'b1;

  bvs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // word store with registered read data
  bvs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
`default_nettype wire

[test/tb_bounded_vector_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bounded_vector_store
// Drives command beats into the bounded vector store and checks every result
// beat against a cycle-free shadow of the array, the fill count and the limit.
// A short directed run covers empty and bad position cases. Random
// segments follow, each with its own count_limit: a fill run up to the limit,
// then mixed commands with growing, shrinking or balanced bias.
// ----------------------------------------------------------------------------
module tb_bounded_vector_store;
  import bvs_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int NUM_SEGS     = 9;
  localparam int RAND_PER_SEG = 120;
  localparam int SETTLE_CYC   = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [CNT_W-1:0] SEG_LIMITS [NUM_SEGS] =
    '{8'd0, 8'd255, 8'd7, 8'd128, 8'd1, 8'd100, 8'd200, 8'd64, 8'd50};

  typedef struct packed {
    cmd_t              op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] wv;
  } cmd_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } result_beat_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // cmd[2:0], position[9:3], write_value[41:10], zero padding above
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // read_value[31:0], element_count[39:32], status[41:40], zero padding above
  logic [OUT_TDATA_W-1:0] out_tdata;

  bounded_vector_store #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // commands waiting for the driver, and results the block still owes
  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];

  // shadow of the array as seen from outside
  logic [WORD_W-1:0] shadow_words [DEPTH];
  logic [CNT_W-1:0]  shadow_count   = '0;
  logic [CNT_W-1:0]  shadow_limit   = LIMIT_RESET;

  // count as the stimulus planner expects it, ahead of the driver
  int plan_count = 0;
  int plan_limit = LIMIT_RESET;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // limit saturates at the array depth
  function automatic int eff_limit(input int lim);
    return (lim > DEPTH) ? DEPTH : lim;
  endfunction

  // one command applied to the shadow array, giving the result it must return
  task automatic apply_command(input cmd_beat_t b);
    result_beat_t r;
    int           pos;
    pos      = b.pos;
    r.value  = '0;
    r.status = ST_OK;
    case (b.op)
      CMD_PUSH: begin
        if (shadow_count >= eff_limit(shadow_limit)) r.status = ST_FULL;
        else begin
          shadow_words[shadow_count] = b.wv;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          shadow_count--;
          r.value = shadow_words[shadow_count];
        end
      end
      CMD_READ_FIRST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.value = shadow_words[0];
      end
      CMD_READ_LAST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.value = shadow_words[shadow_count - 1];
      end
      CMD_READ_AT: begin
        if (pos >= shadow_count) r.status = ST_BADPOS;
        else r.value = shadow_words[pos];
      end
      CMD_WRITE_AT: begin
        if (pos >= shadow_count) r.status = ST_BADPOS;
        else shadow_words[pos] = b.wv;
      end
      CMD_ERASE_AT: begin
        if (pos >= shadow_count) r.status = ST_BADPOS;
        else begin
          // later words move down one place
          for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      default: begin
        shadow_count = '0;
      end
    endcase
    r.count = shadow_count;
    expected_results.push_back(r);
  endtask

  // queue one command and track the count it leaves behind
  task automatic plan_cmd(input cmd_t op, input int pos, input logic [WORD_W-1:0] wv);
    cmd_beat_t b;
    b.op  = op;
    b.pos = pos[POS_W-1:0];
    b.wv  = wv;
    pending_cmds.push_back(b);
    case (op)
      CMD_PUSH:     if (plan_count < eff_limit(plan_limit)) plan_count++;
      CMD_POP:      if (plan_count > 0) plan_count--;
      CMD_ERASE_AT: if (b.pos < plan_count) plan_count--;
      CMD_CLEAR:    plan_count = 0;
      default: ;
    endcase
  endtask

  // mostly random words, with the signed extremes mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // valid positions most of the time, edges favored; else anywhere in range
  function automatic int pick_pos();
    if (plan_count > 0 && $urandom_range(9, 0) < 8) begin
      case ($urandom_range(3, 0))
        0:       return 0;
        1:       return plan_count - 1;
        default: return $urandom_range(plan_count - 1, 0);
      endcase
    end
    return $urandom_range((1 << POS_W) - 1, 0);
  endfunction

  // push up to the limit, then two pushes that must be refused
  task automatic plan_fill();
    while (plan_count < eff_limit(plan_limit)) plan_cmd(CMD_PUSH, pick_pos(), pick_word());
    repeat (2) plan_cmd(CMD_PUSH, pick_pos(), pick_word());
  endtask

  // biased random mix; the bias changes every 25 commands
  task automatic plan_random(input int n);
    int   push_w;
    int   pop_w;
    int   r;
    cmd_t op;
    push_w = 30;
    pop_w  = 20;
    for (int k = 0; k < n; k++) begin
      if (k % 25 == 0) begin
        case ($urandom_range(2, 0))
          0:       begin push_w = 60; pop_w = 8;  end  // growing
          1:       begin push_w = 10; pop_w = 35; end  // shrinking
          default: begin push_w = 30; pop_w = 20; end
        endcase
      end
      r = $urandom_range(99, 0);
      if (r < push_w)              op = CMD_PUSH;
      else if (r < push_w + pop_w) op = CMD_POP;
      else if (r < 99)             op = cmd_t'($urandom_range(CMD_ERASE_AT, CMD_READ_FIRST));
      else                         op = CMD_CLEAR;
      plan_cmd(op, pick_pos(), pick_word());
    end
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0:       begin send_gap_pct = 8;  recv_stall_pct = 60; end
      1:       begin send_gap_pct = 60; recv_stall_pct = 8;  end
      default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // checked between edges so the driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // one limit write, only with the block idle
  task automatic write_limit(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid    <= 1'b0;
    shadow_limit  = v;
    plan_limit    = v;
  endtask

  // driver: a beat is predicted at the edge that accepts it
  always @(posedge clk) begin
    cmd_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        b.op  = cmd_t'(in_tdata[2:0]);
        b.pos = in_tdata[9:3];
        b.wv  = in_tdata[41:10];
        apply_command(b);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
          b = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, b.wv, b.pos, b.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: each result beat against the oldest expectation
  always @(posedge clk) begin
    result_beat_t got;
    result_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value  = out_tdata[31:0];
        got.count  = out_tdata[39:32];
        got.status = status_t'(out_tdata[41:40]);
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: value %h count %0d status %s",
                     got.value, got.count, got.status.name());
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result differs: expected value %h count %0d status %s, got value %h count %0d status %s",
                       want.value, want.count, want.status.name(),
                       got.value, got.count, got.status.name());
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_vector_store: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // empty array: every read fails, clear is harmless
    plan_cmd(CMD_POP, 0, '0);
    plan_cmd(CMD_READ_FIRST, 0, '0);
    plan_cmd(CMD_READ_LAST, 0, '0);
    plan_cmd(CMD_READ_AT, 0, '0);
    plan_cmd(CMD_WRITE_AT, 0, 32'h1234_5678);
    plan_cmd(CMD_ERASE_AT, 0, '0);
    plan_cmd(CMD_CLEAR, 0, '0);
    // signed extremes
    plan_cmd(CMD_PUSH, 0, 32'h7FFF_FFFF);
    plan_cmd(CMD_PUSH, 127, 32'h8000_0000);
    plan_cmd(CMD_PUSH, 0, 32'h0000_0000);
    plan_cmd(CMD_PUSH, 0, 32'hFFFF_FFFF);
    plan_cmd(CMD_READ_FIRST, 0, '0);
    plan_cmd(CMD_READ_LAST, 0, '0);
    // top position and position equal to count are both out of range
    plan_cmd(CMD_READ_AT, 127, '0);
    plan_cmd(CMD_READ_AT, 4, '0);
    plan_cmd(CMD_READ_AT, 2, '0);
    plan_cmd(CMD_WRITE_AT, 3, 32'h5A5A_A5A5);
    // erase from the front, then the last word
    plan_cmd(CMD_ERASE_AT, 0, '0);
    plan_cmd(CMD_READ_AT, 0, '0);
    plan_cmd(CMD_ERASE_AT, 2, '0);
    plan_cmd(CMD_READ_LAST, 0, '0);
    // pop down past empty
    plan_cmd(CMD_POP, 0, '0);
    plan_cmd(CMD_POP, 0, '0);
    plan_cmd(CMD_POP, 0, '0);
    plan_cmd(CMD_CLEAR, 0, '0);

    // random segments, each under its own limit; idling pattern per third
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      set_idle(seg / 3);
      write_limit((seg == NUM_SEGS - 1) ? CNT_W'($urandom_range(128, 1)) : SEG_LIMITS[seg]);
      plan_fill();
      plan_random(RAND_PER_SEG);
    end

    wait_idle();
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("bounded_vector_store: match");
    end else begin
      $display("bounded_vector_store: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

[bounded_vector_store.f]
design/bvs_pkg.sv
design/bvs_mem.sv
design/bvs_ctrl.sv
design/bounded_vector_store.sv
test/tb_bounded_vector_store.sv
